/* hdl/pnm_body_pixel_decoder_top_assert.svh */
// assertion helpers for the pnm body decoder
`ifndef PNM_BODY_PIXEL_DECODER_TOP_ASSERT_SVH
`define PNM_BODY_PIXEL_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define PNM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pnm_pkg.sv */
`default_nettype none
package pnm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int BYTE_W     = 8;
  localparam int STAT_W     = 2;
  localparam int FMT_W      = 3;
  localparam int MAXV_W     = 8;
  localparam int SIZE_W     = 13;
  localparam int NUM_W      = 9;
  localparam int PHASE_W    = 2;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // counters hold column and row numbers below the limits
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // compare width wide enough for the register, the limit and counter + 1
  localparam int WCMP_W = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
  localparam int HCMP_W = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

  localparam int DIV_CNT_W = $clog2(MAXV_W);

  localparam logic [FMT_W-1:0] FMT_P1 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_P2 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_P3 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_P4 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_P5 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_P6 = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_JUNK  = 2'd2;

  localparam logic [PHASE_W-1:0] PH_SKIP    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_NUM     = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COMMENT = 2'd2;

  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  localparam logic [FMT_W-1:0]  RST_FORMAT = FMT_P6;
  localparam logic [MAXV_W-1:0] RST_MAXVAL = 8'd255;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd1;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd1;

  localparam logic [BYTE_W-1:0] CHR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHR_HASH  = 8'h23;

  localparam logic [NUM_W-1:0]  SAT_VALUE  = 9'd256;
  localparam logic [BYTE_W-1:0] FULL_SCALE = 8'd255;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_DIV    = 5'b00100,
    S_FIN    = 5'b01000,
    S_BITS   = 5'b10000
  } state_t;

endpackage
`default_nettype wire

/* hdl/pnm_body_pixel_decoder_top.sv */
// flow: an accepted byte is registered and decoded in S_DECODE, and each result is registered;
//   a P4 byte then steps through S_BITS, a P2/P3 sample through S_DIV (8 iterations of the
//   restoring divider shared by P2 and P3) and S_FIN; S_BITS gives one pixel per cycle while
//   the output is not stalled; input stalls while a byte works
// reset: synchronous active-low rst_n loads config defaults and clears decode state
`default_nettype none
module pnm_body_pixel_decoder_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pnm_pkg::BYTE_W-1:0]      in_body_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pnm_pkg::BYTE_W-1:0]           out_red,
  output logic [pnm_pkg::BYTE_W-1:0]           out_green,
  output logic [pnm_pkg::BYTE_W-1:0]           out_blue,
  output logic [pnm_pkg::STAT_W-1:0]           out_status,
  output logic                                 out_last_pixel,
  output logic                                 out_last_of_item,
  input  wire logic                            cfg_we,
  input  wire logic [pnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int BW = pnm_pkg::BYTE_W;
  localparam int MW = pnm_pkg::MAXV_W;

  pnm_pkg::state_t state_r, state_nxt;

  logic [pnm_pkg::FMT_W-1:0]   fmt_r;
  logic [MW-1:0]               maxv_r;
  logic [pnm_pkg::SIZE_W-1:0]  width_r, height_r;

  logic [BW-1:0]                 byte_r;
  logic [pnm_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [pnm_pkg::NUM_W-1:0]     num_r, num_nxt;
  logic [pnm_pkg::CHAN_W-1:0]    chan_r, chan_nxt;
  logic [BW-1:0]                 held_red_r, held_red_nxt;
  logic [BW-1:0]                 held_green_r, held_green_nxt;
  logic [pnm_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [pnm_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic                          err_r, err_nxt;
  logic                          done_r, done_nxt;
  logic [2:0]                    bit_r, bit_nxt;

  // shared divider
  logic [MW-1:0]                   rem_r, rem_nxt;
  logic [MW-1:0]                   dvd_r, dvd_nxt;
  logic [MW-1:0]                   quo_r, quo_nxt;
  logic [pnm_pkg::DIV_CNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [MW:0]                     div_trial;
  logic                            div_ge;
  logic [2*MW-1:0]                 dividend;

  logic                 out_valid_r;
  logic [BW-1:0]        out_red_r, out_green_r, out_blue_r;
  logic [pnm_pkg::STAT_W-1:0] out_status_r;
  logic                 out_last_pixel_r, out_last_of_item_r;

  logic                 out_free;
  logic                 emit, emit_pixel, emit_last_item, emit_last_pixel;
  logic [BW-1:0]        emit_red, emit_green, emit_blue;
  logic [pnm_pkg::STAT_W-1:0] emit_status;

  logic                 is_digit, is_space, is_hash, is_eol;
  logic [11:0]          num_acc;
  logic [pnm_pkg::NUM_W-1:0] num_sat;
  logic [BW-1:0]        bit_shade;

  logic [pnm_pkg::WCMP_W-1:0] w_ext, w_eff, col_inc;
  logic [pnm_pkg::HCMP_W-1:0] h_ext, h_eff, row_inc;
  logic                       row_end, img_end;

  assign in_stall         = (state_r != pnm_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_status       = out_status_r;
  assign out_last_pixel   = out_last_pixel_r;
  assign out_last_of_item = out_last_of_item_r;

  assign out_free = !out_valid_r || !out_stall;

  // effective image size: zero acts as one, oversize clamps to the limit
  always_comb begin
    w_ext = pnm_pkg::WCMP_W'(width_r);
    h_ext = pnm_pkg::HCMP_W'(height_r);
    if (w_ext == '0) begin
      w_eff = pnm_pkg::WCMP_W'(1);
    end else if (w_ext > pnm_pkg::WCMP_W'(pnm_pkg::MAX_WIDTH)) begin
      w_eff = pnm_pkg::WCMP_W'(pnm_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = pnm_pkg::HCMP_W'(1);
    end else if (h_ext > pnm_pkg::HCMP_W'(pnm_pkg::MAX_HEIGHT)) begin
      h_eff = pnm_pkg::HCMP_W'(pnm_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    col_inc = pnm_pkg::WCMP_W'(col_r) + pnm_pkg::WCMP_W'(1);
    row_inc = pnm_pkg::HCMP_W'(row_r) + pnm_pkg::HCMP_W'(1);
    row_end = (col_inc >= w_eff);
    img_end = (row_inc >= h_eff);
  end

  // character classes and decimal accumulate
  always_comb begin
    is_digit = (byte_r >= pnm_pkg::CHR_0) && (byte_r <= pnm_pkg::CHR_9);
    is_eol   = (byte_r == pnm_pkg::CHR_LF) || (byte_r == pnm_pkg::CHR_CR);
    is_space = is_eol || (byte_r == pnm_pkg::CHR_SPACE) || (byte_r == pnm_pkg::CHR_TAB);
    is_hash  = (byte_r == pnm_pkg::CHR_HASH);
    num_acc  = ({3'b000, num_r} << 3) + ({3'b000, num_r} << 1) + {8'h00, byte_r[3:0]};
    num_sat  = (num_acc > 12'(pnm_pkg::SAT_VALUE)) ? pnm_pkg::SAT_VALUE
                                                   : num_acc[pnm_pkg::NUM_W-1:0];
    // v * 255 as (v << 8) - v, v is known to fit in a byte here
    dividend  = {num_r[MW-1:0], {MW{1'b0}}} - {{MW{1'b0}}, num_r[MW-1:0]};
    div_trial = {rem_r, dvd_r[MW-1]};
    div_ge    = (div_trial >= {1'b0, maxv_r});
    bit_shade = byte_r[bit_r] ? '0 : pnm_pkg::FULL_SCALE;
  end

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    num_nxt         = num_r;
    chan_nxt        = chan_r;
    held_red_nxt    = held_red_r;
    held_green_nxt  = held_green_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    err_nxt         = err_r;
    done_nxt        = done_r;
    bit_nxt         = bit_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    quo_nxt         = quo_r;
    dcnt_nxt        = dcnt_r;
    emit            = 1'b0;
    emit_pixel      = 1'b0;
    emit_last_item  = 1'b0;
    emit_last_pixel = 1'b0;
    emit_red        = '0;
    emit_green      = '0;
    emit_blue       = '0;
    emit_status     = pnm_pkg::ST_OK;

    unique case (state_r)
      pnm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pnm_pkg::S_DECODE;
        end
      end

      pnm_pkg::S_DECODE: begin
        if (out_free) begin
          state_nxt = pnm_pkg::S_IDLE;
          if (!err_r && !done_r) begin
            case (fmt_r)
              pnm_pkg::FMT_P1, pnm_pkg::FMT_P2, pnm_pkg::FMT_P3: begin
                case (phase_r)
                  pnm_pkg::PH_COMMENT: begin
                    if (is_eol) begin
                      phase_nxt = pnm_pkg::PH_SKIP;
                    end
                  end
                  pnm_pkg::PH_NUM: begin
                    if (is_digit) begin
                      num_nxt = num_sat;
                    end else if (is_space || is_hash) begin
                      num_nxt   = '0;
                      phase_nxt = is_hash ? pnm_pkg::PH_COMMENT : pnm_pkg::PH_SKIP;
                      if (num_r > {1'b0, maxv_r}) begin
                        emit        = 1'b1;
                        emit_status = pnm_pkg::ST_RANGE;
                      end else if (fmt_r == pnm_pkg::FMT_P1) begin
                        emit       = 1'b1;
                        emit_pixel = 1'b1;
                        emit_red   = (num_r == '0) ? pnm_pkg::FULL_SCALE : '0;
                        emit_green = emit_red;
                        emit_blue  = emit_red;
                      end else if (maxv_r == '0) begin
                        // only zero gets here, it scales to zero
                        quo_nxt   = '0;
                        state_nxt = pnm_pkg::S_FIN;
                      end else begin
                        rem_nxt   = dividend[2*MW-1:MW];
                        dvd_nxt   = dividend[MW-1:0];
                        quo_nxt   = '0;
                        dcnt_nxt  = '0;
                        state_nxt = pnm_pkg::S_DIV;
                      end
                    end else begin
                      emit        = 1'b1;
                      emit_status = pnm_pkg::ST_JUNK;
                    end
                  end
                  default: begin
                    if (is_digit) begin
                      num_nxt   = pnm_pkg::NUM_W'(byte_r[3:0]);
                      phase_nxt = pnm_pkg::PH_NUM;
                    end else if (is_space) begin
                      phase_nxt = pnm_pkg::PH_SKIP;
                    end else if (is_hash) begin
                      phase_nxt = pnm_pkg::PH_COMMENT;
                    end else begin
                      emit        = 1'b1;
                      emit_status = pnm_pkg::ST_JUNK;
                    end
                  end
                endcase
              end
              pnm_pkg::FMT_P4: begin
                bit_nxt   = 3'd7;
                state_nxt = pnm_pkg::S_BITS;
              end
              pnm_pkg::FMT_P5: begin
                emit       = 1'b1;
                emit_pixel = 1'b1;
                emit_red   = byte_r;
                emit_green = byte_r;
                emit_blue  = byte_r;
              end
              pnm_pkg::FMT_P6: begin
                if (chan_r == pnm_pkg::CH_RED) begin
                  held_red_nxt = byte_r;
                  chan_nxt     = pnm_pkg::CH_GREEN;
                end else if (chan_r == pnm_pkg::CH_GREEN) begin
                  held_green_nxt = byte_r;
                  chan_nxt       = pnm_pkg::CH_BLUE;
                end else begin
                  chan_nxt   = pnm_pkg::CH_RED;
                  emit       = 1'b1;
                  emit_pixel = 1'b1;
                  emit_red   = held_red_r;
                  emit_green = held_green_r;
                  emit_blue  = byte_r;
                end
              end
              default: begin
              end
            endcase
            emit_last_item = emit;
            if (emit && !emit_pixel) begin
              err_nxt   = 1'b1;
              phase_nxt = pnm_pkg::PH_SKIP;
              num_nxt   = '0;
            end
          end
        end
      end

      pnm_pkg::S_DIV: begin
        // one quotient bit per cycle
        rem_nxt  = div_ge ? MW'(div_trial - {1'b0, maxv_r}) : div_trial[MW-1:0];
        dvd_nxt  = {dvd_r[MW-2:0], 1'b0};
        quo_nxt  = {quo_r[MW-2:0], div_ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == pnm_pkg::DIV_CNT_W'(MW - 1)) begin
          state_nxt = pnm_pkg::S_FIN;
        end
      end

      pnm_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = pnm_pkg::S_IDLE;
          if (fmt_r == pnm_pkg::FMT_P2) begin
            emit       = 1'b1;
            emit_pixel = 1'b1;
            emit_red   = quo_r;
            emit_green = quo_r;
            emit_blue  = quo_r;
          end else if (chan_r == pnm_pkg::CH_RED) begin
            held_red_nxt = quo_r;
            chan_nxt     = pnm_pkg::CH_GREEN;
          end else if (chan_r == pnm_pkg::CH_GREEN) begin
            held_green_nxt = quo_r;
            chan_nxt       = pnm_pkg::CH_BLUE;
          end else begin
            chan_nxt   = pnm_pkg::CH_RED;
            emit       = 1'b1;
            emit_pixel = 1'b1;
            emit_red   = held_red_r;
            emit_green = held_green_r;
            emit_blue  = quo_r;
          end
          emit_last_item = emit;
        end
      end

      pnm_pkg::S_BITS: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_pixel     = 1'b1;
          emit_red       = bit_shade;
          emit_green     = bit_shade;
          emit_blue      = bit_shade;
          // row padding bits are dropped, the image end always falls on a row end
          emit_last_item = row_end || (bit_r == 3'd0);
          bit_nxt        = bit_r - 3'd1;
          if (emit_last_item) begin
            state_nxt = pnm_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = pnm_pkg::S_IDLE;
      end
    endcase

    // pixel position advance
    if (emit && emit_pixel) begin
      if (row_end) begin
        col_nxt = '0;
        if (img_end) begin
          row_nxt         = '0;
          done_nxt        = 1'b1;
          emit_last_pixel = 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pnm_pkg::S_IDLE;
      fmt_r        <= pnm_pkg::RST_FORMAT;
      maxv_r       <= pnm_pkg::RST_MAXVAL;
      width_r      <= pnm_pkg::RST_WIDTH;
      height_r     <= pnm_pkg::RST_HEIGHT;
      phase_r      <= pnm_pkg::PH_SKIP;
      num_r        <= '0;
      chan_r       <= pnm_pkg::CH_RED;
      held_red_r   <= '0;
      held_green_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      err_r        <= 1'b0;
      done_r       <= 1'b0;
      bit_r        <= '0;
      dcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      num_r        <= num_nxt;
      chan_r       <= chan_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      err_r        <= err_nxt;
      done_r       <= done_nxt;
      bit_r        <= bit_nxt;
      dcnt_r       <= dcnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          pnm_pkg::CFG_FORMAT: fmt_r    <= cfg_data[pnm_pkg::FMT_W-1:0];
          pnm_pkg::CFG_MAXVAL: maxv_r   <= cfg_data[MW-1:0];
          pnm_pkg::CFG_WIDTH:  width_r  <= cfg_data[pnm_pkg::SIZE_W-1:0];
          pnm_pkg::CFG_HEIGHT: height_r <= cfg_data[pnm_pkg::SIZE_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == pnm_pkg::S_IDLE) && in_valid) begin
      byte_r <= in_body_byte;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    if (emit) begin
      out_red_r          <= emit_red;
      out_green_r        <= emit_green;
      out_blue_r         <= emit_blue;
      out_status_r       <= emit_status;
      out_last_pixel_r   <= emit_last_pixel;
      out_last_of_item_r <= emit_last_item;
    end
  end

`include "pnm_body_pixel_decoder_top_assert.svh"

  `PNM_ASSERT_NOW(a_sticky_err, err_r, !emit, "result produced after sticky error")
  `PNM_ASSERT_NOW(a_done_quiet, done_r, !emit, "result produced after image end")
  `PNM_ASSERT_NOW(a_div_nonzero, state_r == pnm_pkg::S_DIV, maxv_r != '0, "divide by zero")
  `PNM_ASSERT_NEXT(a_err_latch, emit && (emit_status != pnm_pkg::ST_OK), err_r, "error not latched")

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam logic [pnm_pkg::FMT_W-1:0] FMT_NONE_A = 3'd6;
  localparam logic [pnm_pkg::FMT_W-1:0] FMT_NONE_B = 3'd7;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [pnm_pkg::BYTE_W-1:0] red;
    logic [pnm_pkg::BYTE_W-1:0] green;
    logic [pnm_pkg::BYTE_W-1:0] blue;
    logic [pnm_pkg::STAT_W-1:0] status;
    logic                       last_pixel;
    logic                       last_of_item;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [pnm_pkg::BYTE_W-1:0]     in_body_byte = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [pnm_pkg::BYTE_W-1:0]     out_red;
  logic [pnm_pkg::BYTE_W-1:0]     out_green;
  logic [pnm_pkg::BYTE_W-1:0]     out_blue;
  logic [pnm_pkg::STAT_W-1:0]     out_status;
  logic                           out_last_pixel;
  logic                           out_last_of_item;
  logic                           cfg_we = 1'b0;
  logic [pnm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pnm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pnm_body_pixel_decoder_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_body_byte     (in_body_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_status       (out_status),
    .out_last_pixel   (out_last_pixel),
    .out_last_of_item (out_last_of_item),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [pnm_pkg::BYTE_W-1:0] pending_bytes[$];
  pixel_t            expected_pixels[$];
  int unsigned       queued_total = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  bit                no_idle = 1'b0;

  // decoder shadow: configuration and decode state
  logic [pnm_pkg::FMT_W-1:0]   m_format;
  logic [pnm_pkg::MAXV_W-1:0]  m_maxval;
  logic [pnm_pkg::SIZE_W-1:0]  m_width;
  logic [pnm_pkg::SIZE_W-1:0]  m_height;
  logic [pnm_pkg::PHASE_W-1:0] m_phase;
  int unsigned                 m_number;
  logic [pnm_pkg::CHAN_W-1:0]  m_chan;
  logic [pnm_pkg::BYTE_W-1:0]  m_red;
  logic [pnm_pkg::BYTE_W-1:0]  m_green;
  int unsigned                 m_col;
  int unsigned                 m_row;
  bit                          m_error;
  bit                          m_done;
  pixel_t                      byte_pixels[8];
  int                          byte_count;

  task automatic reset_shadow();
    m_format = pnm_pkg::RST_FORMAT;
    m_maxval = pnm_pkg::RST_MAXVAL;
    m_width  = pnm_pkg::RST_WIDTH;
    m_height = pnm_pkg::RST_HEIGHT;
    m_phase  = pnm_pkg::PH_SKIP;
    m_number = 0;
    m_chan   = pnm_pkg::CH_RED;
    m_red    = '0;
    m_green  = '0;
    m_col    = 0;
    m_row    = 0;
    m_error  = 1'b0;
    m_done   = 1'b0;
  endtask

  function automatic int unsigned eff_size(input logic [pnm_pkg::SIZE_W-1:0] v,
                                           input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic emit_pixel(input logic [pnm_pkg::BYTE_W-1:0] r,
                            input logic [pnm_pkg::BYTE_W-1:0] g,
                            input logic [pnm_pkg::BYTE_W-1:0] b);
    pixel_t p;
    int unsigned w;
    int unsigned h;
    w = eff_size(m_width, pnm_pkg::MAX_WIDTH);
    h = eff_size(m_height, pnm_pkg::MAX_HEIGHT);
    p = '0;
    p.red    = r;
    p.green  = g;
    p.blue   = b;
    p.status = pnm_pkg::ST_OK;
    if (m_col + 1 >= w) begin
      m_col = 0;
      if (m_row + 1 >= h) begin
        m_row = 0;
        m_done = 1'b1;
        p.last_pixel = 1'b1;
      end else begin
        m_row++;
      end
    end else begin
      m_col++;
    end
    byte_pixels[byte_count] = p;
    byte_count++;
  endtask

  task automatic emit_error(input logic [pnm_pkg::STAT_W-1:0] code);
    pixel_t p;
    p = '0;
    p.status = code;
    byte_pixels[byte_count] = p;
    byte_count++;
    m_error  = 1'b1;
    m_phase  = pnm_pkg::PH_SKIP;
    m_number = 0;
  endtask

  task automatic take_sample(input int unsigned v);
    logic [pnm_pkg::BYTE_W-1:0] s;
    if (v > m_maxval) begin
      emit_error(pnm_pkg::ST_RANGE);
    end else if (m_format == pnm_pkg::FMT_P1) begin
      s = (v == 0) ? pnm_pkg::FULL_SCALE : 8'd0;
      emit_pixel(s, s, s);
    end else begin
      s = (m_maxval != 0) ? 8'((v * pnm_pkg::FULL_SCALE) / m_maxval) : 8'd0;
      if (m_format == pnm_pkg::FMT_P2) begin
        emit_pixel(s, s, s);
      end else if (m_chan == pnm_pkg::CH_RED) begin
        m_red = s;
        m_chan = pnm_pkg::CH_GREEN;
      end else if (m_chan == pnm_pkg::CH_GREEN) begin
        m_green = s;
        m_chan = pnm_pkg::CH_BLUE;
      end else begin
        m_chan = pnm_pkg::CH_RED;
        emit_pixel(m_red, m_green, s);
      end
    end
  endtask

  task automatic parse_char(input logic [pnm_pkg::BYTE_W-1:0] c);
    bit          digit;
    bit          space;
    int unsigned v;
    digit = (c >= pnm_pkg::CHR_0) && (c <= pnm_pkg::CHR_9);
    space = (c == pnm_pkg::CHR_SPACE) || (c == pnm_pkg::CHR_TAB) ||
            (c == pnm_pkg::CHR_LF) || (c == pnm_pkg::CHR_CR);
    if (m_phase == pnm_pkg::PH_COMMENT) begin
      if (c == pnm_pkg::CHR_LF || c == pnm_pkg::CHR_CR) m_phase = pnm_pkg::PH_SKIP;
    end else if (m_phase == pnm_pkg::PH_NUM) begin
      if (digit) begin
        v = m_number * 10 + (c - pnm_pkg::CHR_0);
        m_number = (v > pnm_pkg::SAT_VALUE) ? pnm_pkg::SAT_VALUE : v;
      end else if (space || c == pnm_pkg::CHR_HASH) begin
        v = m_number;
        m_number = 0;
        m_phase = (c == pnm_pkg::CHR_HASH) ? pnm_pkg::PH_COMMENT : pnm_pkg::PH_SKIP;
        take_sample(v);
      end else begin
        emit_error(pnm_pkg::ST_JUNK);
      end
    end else begin
      if (digit) begin
        m_number = c - pnm_pkg::CHR_0;
        m_phase = pnm_pkg::PH_NUM;
      end else if (space) begin
        m_phase = pnm_pkg::PH_SKIP;
      end else if (c == pnm_pkg::CHR_HASH) begin
        m_phase = pnm_pkg::PH_COMMENT;
      end else begin
        emit_error(pnm_pkg::ST_JUNK);
      end
    end
  endtask

  task automatic decode_byte(input logic [pnm_pkg::BYTE_W-1:0] c);
    int unsigned                w;
    int                         b;
    bit                         row_end;
    logic [pnm_pkg::BYTE_W-1:0] s;
    byte_count = 0;
    if (!m_error && !m_done) begin
      case (m_format)
        pnm_pkg::FMT_P1, pnm_pkg::FMT_P2, pnm_pkg::FMT_P3: parse_char(c);
        pnm_pkg::FMT_P4: begin
          // msb first, the rest of the byte is padding once the row ends
          w = eff_size(m_width, pnm_pkg::MAX_WIDTH);
          for (b = 7; b >= 0 && !m_done; b--) begin
            s = c[b] ? 8'd0 : pnm_pkg::FULL_SCALE;
            row_end = (m_col + 1 >= w);
            emit_pixel(s, s, s);
            if (row_end) break;
          end
        end
        pnm_pkg::FMT_P5: emit_pixel(c, c, c);
        pnm_pkg::FMT_P6: begin
          if (m_chan == pnm_pkg::CH_RED) begin
            m_red = c;
            m_chan = pnm_pkg::CH_GREEN;
          end else if (m_chan == pnm_pkg::CH_GREEN) begin
            m_green = c;
            m_chan = pnm_pkg::CH_BLUE;
          end else begin
            m_chan = pnm_pkg::CH_RED;
            emit_pixel(m_red, m_green, c);
          end
        end
        default: ;
      endcase
    end
    if (byte_count > 0) byte_pixels[byte_count-1].last_of_item = 1'b1;
    for (int k = 0; k < byte_count; k++) expected_pixels.push_back(byte_pixels[k]);
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input side: one byte per transfer from the pending queue
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_body_byte);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_body_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result side: random stall, check every transfer against the oldest pixel
  int     stall_left = 0;
  pixel_t want_px;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result expected none actual rgb %0d %0d %0d status %0d",
                     $time, out_red, out_green, out_blue, out_status);
        end else begin
          want_px = expected_pixels.pop_front();
          compare_field("red", want_px.red, out_red);
          compare_field("green", want_px.green, out_green);
          compare_field("blue", want_px.blue, out_blue);
          compare_field("status", want_px.status, out_status);
          compare_field("last_pixel", want_px.last_pixel, out_last_pixel);
          compare_field("last_of_item", want_px.last_of_item, out_last_of_item);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_byte(input logic [pnm_pkg::BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [pnm_pkg::BYTE_W-1:0] pick_space();
    case ($urandom_range(0, 3))
      0: return pnm_pkg::CHR_SPACE;
      1: return pnm_pkg::CHR_TAB;
      2: return pnm_pkg::CHR_LF;
      default: return pnm_pkg::CHR_CR;
    endcase
  endfunction

  // whitespace run, or a comment closed by a line end
  task automatic push_separator();
    logic [pnm_pkg::BYTE_W-1:0] b;
    if ($urandom_range(0, 5) == 0) begin
      push_byte(pnm_pkg::CHR_HASH);
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == pnm_pkg::CHR_LF || b == pnm_pkg::CHR_CR) b = pnm_pkg::CHR_SPACE;
        push_byte(b);
      end
      push_byte($urandom_range(0, 1) ? pnm_pkg::CHR_LF : pnm_pkg::CHR_CR);
    end else begin
      repeat ($urandom_range(1, 3)) push_byte(pick_space());
    end
  endtask

  task automatic push_number(input int unsigned v);
    logic [pnm_pkg::BYTE_W-1:0] digits[$];
    do begin
      digits.push_front(pnm_pkg::CHR_0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 5) == 0) push_byte(pnm_pkg::CHR_0);
    foreach (digits[i]) push_byte(digits[i]);
    push_separator();
  endtask

  function automatic int unsigned pick_sample();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return m_maxval;
      default: return $urandom_range(0, m_maxval);
    endcase
  endfunction

  // well-formed content for the current format
  task automatic queue_phase(input int unsigned n);
    int unsigned stop;
    stop = queued_total + n;
    while (queued_total < stop) begin
      if (m_format <= pnm_pkg::FMT_P3) push_number(pick_sample());
      else push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [pnm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pnm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pnm_pkg::CFG_FORMAT: m_format = data[pnm_pkg::FMT_W-1:0];
      pnm_pkg::CFG_MAXVAL: m_maxval = data[pnm_pkg::MAXV_W-1:0];
      pnm_pkg::CFG_WIDTH:  m_width = data;
      pnm_pkg::CFG_HEIGHT: m_height = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // upper data bits are junk for the narrow registers
  task automatic set_format(input logic [pnm_pkg::FMT_W-1:0] f);
    write_reg(pnm_pkg::CFG_FORMAT, {10'($urandom), f});
  endtask

  task automatic set_maxval(input logic [pnm_pkg::MAXV_W-1:0] m);
    write_reg(pnm_pkg::CFG_MAXVAL, {5'($urandom), m});
  endtask

  initial begin
    int unsigned                start;
    int                         r;
    int                         guard;
    logic [pnm_pkg::BYTE_W-1:0] b;

    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset height is one row, open it up before any pixel
    write_reg(pnm_pkg::CFG_HEIGHT, 13'd8191);
    write_reg(pnm_pkg::CFG_WIDTH, 13'd3);
    set_maxval(8'd255);
    set_format(pnm_pkg::FMT_P6);
    push_byte(8'h00); push_byte(8'hff); push_byte(8'h80);
    wait_idle();
    set_format(pnm_pkg::FMT_P5);
    push_byte(8'h00); push_byte(8'hff);
    wait_idle();
    set_format(pnm_pkg::FMT_P4);
    write_reg(pnm_pkg::CFG_WIDTH, 13'd0);
    push_byte(8'hff);
    wait_idle();
    write_reg(pnm_pkg::CFG_WIDTH, 13'd4096);
    push_byte(8'ha5);
    wait_idle();
    // column counter sits past the new width and wraps
    write_reg(pnm_pkg::CFG_WIDTH, 13'd5);
    push_byte(8'h3c);
    wait_idle();
    set_format(pnm_pkg::FMT_P1);
    push_text("0 9 ");
    wait_idle();
    set_format(pnm_pkg::FMT_P2);
    push_text("255\r");
    wait_idle();
    set_maxval(8'd0);
    push_text("0\t");
    wait_idle();
    set_format(pnm_pkg::FMT_P3);
    set_maxval(8'd100);
    push_text("100 0#\n50\n");
    wait_idle();
    set_format(FMT_NONE_A);
    push_byte(8'h00);
    wait_idle();
    set_format(FMT_NONE_B);
    push_byte(8'hff);
    wait_idle();

    start = queued_total;
    while (queued_total - start < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0)
        set_format($urandom_range(0, 1) ? FMT_NONE_B : FMT_NONE_A);
      else
        set_format(3'($urandom_range(pnm_pkg::FMT_P6, pnm_pkg::FMT_P1)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: write_reg(pnm_pkg::CFG_WIDTH, 13'd0);
          1: write_reg(pnm_pkg::CFG_WIDTH, 13'd4096);
          2: write_reg(pnm_pkg::CFG_WIDTH, 13'd8191);
          3: write_reg(pnm_pkg::CFG_WIDTH, 13'd4095);
          default: write_reg(pnm_pkg::CFG_WIDTH, 13'($urandom_range(1, 9)));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: set_maxval(8'd0);
          1: set_maxval(8'd1);
          2: set_maxval(8'd255);
          default: set_maxval(8'($urandom_range(1, 255)));
        endcase
      end
      // every height here acts as the full limit so the image stays open
      if ($urandom_range(0, 7) == 0)
        write_reg(pnm_pkg::CFG_HEIGHT, $urandom_range(0, 1) ? 13'd4096 : 13'd8191);
      if (m_format > pnm_pkg::FMT_P6) begin
        repeat ($urandom_range(3, 8)) push_byte(8'($urandom_range(0, 255)));
        start += queued_total - start;
      end else begin
        queue_phase($urandom_range(10, 30));
      end
      wait_idle();
    end
    no_idle = 1'b0;

    // both end states are sticky, the seed picks which one closes the run
    if ($urandom_range(0, 1)) begin
      set_format(3'($urandom_range(pnm_pkg::FMT_P6, pnm_pkg::FMT_P4)));
      write_reg(pnm_pkg::CFG_WIDTH, 13'($urandom_range(0, 4)));
      case ($urandom_range(0, 2))
        0: write_reg(pnm_pkg::CFG_HEIGHT, 13'd0);
        1: write_reg(pnm_pkg::CFG_HEIGHT, 13'd1);
        default: write_reg(pnm_pkg::CFG_HEIGHT, 13'(m_row + 2));
      endcase
      guard = 0;
      while (!m_done && guard < 200) begin
        queue_phase(4);
        wait_idle();
        guard++;
      end
    end else begin
      set_format(3'($urandom_range(pnm_pkg::FMT_P3, pnm_pkg::FMT_P1)));
      set_maxval(8'($urandom_range(0, 255)));
      queue_phase(6);
      r = $urandom_range(0, 2);
      if (r == 0) begin
        if ($urandom_range(0, 1))
          push_byte(8'($urandom_range(pnm_pkg::CHR_0, pnm_pkg::CHR_9)));
        do b = 8'($urandom_range(0, 255));
        while ((b >= pnm_pkg::CHR_0 && b <= pnm_pkg::CHR_9) || b == pnm_pkg::CHR_SPACE ||
               b == pnm_pkg::CHR_TAB || b == pnm_pkg::CHR_LF || b == pnm_pkg::CHR_CR ||
               b == pnm_pkg::CHR_HASH);
        push_byte(b);
      end else if (r == 1) begin
        push_number($urandom_range(m_maxval + 1, 300));
      end else begin
        // far past the saturation point
        push_number($urandom_range(1000, 99999));
      end
    end
    // nothing may come out of these
    repeat (8) push_byte(8'($urandom_range(0, 255)));
    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
